// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file fbpa_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/fbpa_pkg.sv =====
// Types and constants of the fixed block pool allocator
package fbpa_pkg;

   localparam int MaxBlocks  = 256;
   localparam int IndexWidth = $clog2(MaxBlocks);
   localparam int LinkWidth  = $clog2(MaxBlocks + 1);
   localparam int CountWidth = 9;

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EXHAUSTED = 2'd1,
      ST_RANGE     = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type         cmd;
      logic [7:0]      block_index;
   } req_payload_type;

   typedef struct packed {
      status_type      status;
      logic [7:0]      granted_index;
      logic [8:0]      in_use;
   } rsp_payload_type;

   typedef enum logic {
      FSM_IDLE,
      FSM_EXEC
   } fsm_state_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } dp_cmd_type;

   typedef struct packed {
      logic out_blocked;
   } dp_status_type;

endpackage

// ===== hw/rtl/fbpa_ctrl.sv =====
// Controller state machine: accept, then execute once the output register is free
module fbpa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  fbpa_pkg::dp_status_type dp_status,
   output fbpa_pkg::dp_cmd_type    dp_cmd
);
   import fbpa_pkg::*;

   fsm_state_type state_ff;
   fsm_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_stall      = 1'b1;
      dp_cmd.capture = 1'b0;
      dp_cmd.execute = 1'b0;
      unique case (state_ff)
         FSM_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               dp_cmd.capture = 1'b1;
               state_in       = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            if (!dp_status.out_blocked) begin
               dp_cmd.execute = 1'b1;
               state_in       = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/fbpa_dpath.sv =====
// Datapath: pool registers, free-list link memory, result register
module fbpa_dpath (
   input  logic                     clock,
   input  logic                     reset,
   input  fbpa_pkg::req_payload_type req_data,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output fbpa_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [8:0]               csr_wdata,
   input  fbpa_pkg::dp_cmd_type      dp_cmd,
   output fbpa_pkg::dp_status_type   dp_status
);
   import fbpa_pkg::*;

   logic [LinkWidth-1:0]  link_mem [MaxBlocks];
   logic [LinkWidth-1:0]  link_rd_ff;

   logic [8:0]            block_count_ff;
   logic [LinkWidth-1:0]  free_head_ff;
   logic [LinkWidth-1:0]  free_head_in;
   logic [LinkWidth-1:0]  bump_next_ff;
   logic [LinkWidth-1:0]  bump_next_in;
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   req_payload_type       item_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_payload_type       rsp_data_ff;
   rsp_payload_type       rsp_data_in;

   logic [CountWidth-1:0] pool_size;
   logic                  mem_wr;

   assign csr_ready             = 1'b1;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_data              = rsp_data_ff;
   assign dp_status.out_blocked = rsp_valid_ff && rsp_stall;

   // block_count saturates at the built capacity
   assign pool_size = (block_count_ff > CountWidth'(MaxBlocks)) ?
                      CountWidth'(MaxBlocks) : block_count_ff;

   always_comb begin
      free_head_in              = free_head_ff;
      bump_next_in              = bump_next_ff;
      count_in                  = count_ff;
      mem_wr                    = 1'b0;
      rsp_data_in.status        = ST_OK;
      rsp_data_in.granted_index = '0;
      case (item_ff.cmd)
         CMD_ALLOC: begin
            if (count_ff >= pool_size) begin
               rsp_data_in.status = ST_EXHAUSTED;
            end else if (free_head_ff < LinkWidth'(MaxBlocks)) begin
               rsp_data_in.granted_index = 8'(free_head_ff[IndexWidth-1:0]);
               free_head_in              = link_rd_ff;
               count_in                  = count_ff + 1'b1;
            end else if (bump_next_ff < LinkWidth'(MaxBlocks)) begin
               rsp_data_in.granted_index = 8'(bump_next_ff[IndexWidth-1:0]);
               bump_next_in              = bump_next_ff + 1'b1;
               count_in                  = count_ff + 1'b1;
            end else begin
               rsp_data_in.status = ST_EXHAUSTED;
            end
         end
         CMD_FREE: begin
            if (CountWidth'(item_ff.block_index) >= pool_size) begin
               rsp_data_in.status = ST_RANGE;
            end else if (count_ff == '0) begin
               rsp_data_in.status = ST_EMPTY;
            end else begin
               mem_wr       = 1'b1;
               free_head_in = LinkWidth'(item_ff.block_index);
               count_in     = count_ff - 1'b1;
            end
         end
         CMD_CLEAR: begin
            free_head_in = LinkWidth'(MaxBlocks);
            bump_next_in = '0;
            count_in     = '0;
         end
         default: begin
         end
      endcase
      rsp_data_in.in_use = 9'(count_in);
   end

   always_comb begin
      if (dp_cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= 9'd256;
         free_head_ff   <= LinkWidth'(MaxBlocks);
         bump_next_ff   <= '0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            block_count_ff <= csr_wdata;
         end
         if (dp_cmd.execute) begin
            free_head_ff <= free_head_in;
            bump_next_ff <= bump_next_in;
            count_ff     <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         item_ff <= req_data;
      end
      if (dp_cmd.execute) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // link of the current head is fetched at the input transfer into link_rd_ff and used in the execute step
   always_ff @(posedge clock) begin
      if (dp_cmd.execute && mem_wr) begin
         link_mem[item_ff.block_index[IndexWidth-1:0]] <= free_head_ff;
      end
      if (dp_cmd.capture) begin
         link_rd_ff <= link_mem[free_head_ff[IndexWidth-1:0]];
      end
   end

endmodule

// ===== hw/rtl/fixed_block_pool_allocator.sv =====
// Fixed block pool allocator: a request is captured at the input transfer and executed
// in the EXEC state once the output register is free, which registers the result there.
// One item is in flight at a time: no new request is taken until the current one executes;
// a held result stalls the execute step only.
// Synchronous active-high reset: empty free list, bump counter and count at 0,
// block_count at 256. The link memory is not cleared; no item waits after reset.
module fixed_block_pool_allocator (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  fbpa_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output fbpa_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [8:0]               csr_wdata
);
   import fbpa_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   fbpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   fbpa_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

endmodule

// ===== hw/rtl/fbpa_checker.sv =====
// Port-level checker for the allocator, bound to the top level
`include "assert_macros.svh"

module fbpa_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input fbpa_pkg::rsp_payload_type rsp_data
);
   import fbpa_pkg::*;

   // held result stays put
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   // one item in flight: no transfer in the cycle after a transfer
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall)
   // failed operations grant nothing
   `ASSERT_IMPLY(a_fail_no_grant, clock, reset, rsp_valid && rsp_data.status != ST_OK,
                 rsp_data.granted_index == 8'd0)
   // nothing-allocated failure only with an empty pool
   `ASSERT_IMPLY(a_empty_count, clock, reset, rsp_valid && rsp_data.status == ST_EMPTY,
                 rsp_data.in_use == 9'd0)
   // count never beyond capacity
   `ASSERT_IMPLY(a_count_cap, clock, reset, rsp_valid, rsp_data.in_use <= 9'(MaxBlocks))

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (.*);

// ===== bench/fixed_block_pool_allocator_tb.sv =====
// Self-checking bench for the fixed block pool allocator: directed and random traffic against a pool model
module fixed_block_pool_allocator_tb;
   import fbpa_pkg::*;

   localparam int CycleLimit = 300000;
   localparam int HoldCycles = 80;
   localparam int DrainPause = 4;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic [8:0]      csr_wdata = '0;

   // pool model state
   logic [8:0] link_mem [MaxBlocks];
   logic [8:0] head_ptr = 9'(MaxBlocks);
   logic [8:0] bump_ptr = '0;
   logic [8:0] live_count = '0;
   logic [8:0] pool_limit = 9'(MaxBlocks);

   req_payload_type cmd_queue[$];
   rsp_payload_type outcome_queue[$];
   logic [7:0]      live_blocks[$];

   logic idle_enable = 1'b1;
   int   gap_left = 0;
   int   stall_left = 0;
   int   hold_asks = 0;
   int   holds_served = 0;
   int   error_count = 0;
   int   cycle_count = 0;

   fixed_block_pool_allocator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [8:0] active_blocks();
      return (pool_limit > 9'(MaxBlocks)) ? 9'(MaxBlocks) : pool_limit;
   endfunction

   function automatic rsp_payload_type pool_outcome(req_payload_type op);
      rsp_payload_type res;
      logic [8:0]      limit;
      res = '0;
      res.status = ST_OK;
      limit = active_blocks();
      case (op.cmd)
         CMD_ALLOC: begin
            if (live_count >= limit) begin
               res.status = ST_EXHAUSTED;
            end else if (head_ptr < 9'(MaxBlocks)) begin
               res.granted_index = head_ptr[7:0];
               head_ptr = link_mem[head_ptr[7:0]];
               live_count = live_count + 1'b1;
            end else if (bump_ptr < 9'(MaxBlocks)) begin
               res.granted_index = bump_ptr[7:0];
               bump_ptr = bump_ptr + 1'b1;
               live_count = live_count + 1'b1;
            end else begin
               res.status = ST_EXHAUSTED;
            end
         end
         CMD_FREE: begin
            if ({1'b0, op.block_index} >= limit) begin
               res.status = ST_RANGE;
            end else if (live_count == '0) begin
               res.status = ST_EMPTY;
            end else begin
               link_mem[op.block_index] = head_ptr;
               head_ptr = {1'b0, op.block_index};
               live_count = live_count - 1'b1;
            end
         end
         CMD_CLEAR: begin
            head_ptr = 9'(MaxBlocks);
            bump_ptr = '0;
            live_count = '0;
         end
         default: ;
      endcase
      res.in_use = live_count;
      return res;
   endfunction

   task automatic issue(cmd_type cmd, logic [7:0] idx);
      req_payload_type op;
      rsp_payload_type res;
      op.cmd = cmd;
      op.block_index = idx;
      res = pool_outcome(op);
      if (cmd == CMD_ALLOC && res.status == ST_OK)
         live_blocks.push_back(res.granted_index);
      if (cmd == CMD_CLEAR)
         live_blocks.delete();
      cmd_queue.push_back(op);
      outcome_queue.push_back(res);
   endtask

   // only touched once every outstanding result has come back
   task automatic set_block_count(logic [8:0] value);
      while (cmd_queue.size() > 0 || outcome_queue.size() > 0)
         @(posedge clock);
      repeat (DrainPause) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      pool_limit = value;
      @(negedge clock);
   endtask

   task automatic random_traffic(int count, int alloc_pct, int clear_pct);
      int         roll;
      int         pos;
      logic [8:0] limit;
      logic [7:0] idx;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(0, 99);
         limit = active_blocks();
         if (roll < alloc_pct) begin
            issue(CMD_ALLOC, 8'($urandom_range(0, 255)));
         end else if (roll < alloc_pct + clear_pct) begin
            issue(CMD_CLEAR, 8'($urandom_range(0, 255)));
         end else if (roll < alloc_pct + clear_pct + 3) begin
            issue(CMD_NOP, 8'($urandom_range(0, 255)));
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 70 && live_blocks.size() > 0) begin
               pos = $urandom_range(0, live_blocks.size() - 1);
               idx = live_blocks[pos];
               live_blocks.delete(pos);
            end else if (roll < 90) begin
               idx = 8'($urandom_range(0, 255));
            end else begin
               // just inside or just outside the pool
               idx = $urandom_range(0, 1) ? 8'(limit - 1'b1) : limit[7:0];
            end
            issue(CMD_FREE, idx);
         end
      end
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (cmd_queue.size() > 0) begin
            req_data <= cmd_queue.pop_front();
            req_valid <= 1'b1;
            if (idle_enable && $urandom_range(0, 99) < 15)
               gap_left <= $urandom_range(1, 12);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver back-pressure, including the long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (holds_served < hold_asks) begin
         holds_served <= holds_served + 1;
         stall_left <= HoldCycles;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (idle_enable && $urandom_range(0, 99) < 12) begin
         stall_left <= $urandom_range(0, 11);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // result checker
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (outcome_queue.size() == 0) begin
            if (error_count < 10)
               $display("unexpected transfer: status %0d index %0d in_use %0d",
                        rsp_data.status, rsp_data.granted_index, rsp_data.in_use);
            error_count <= error_count + 1;
         end else begin
            want = outcome_queue.pop_front();
            if (rsp_data.status !== want.status
                  || rsp_data.granted_index !== want.granted_index
                  || rsp_data.in_use !== want.in_use) begin
               if (error_count < 10)
                  $display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d (status/index/in_use)",
                           want.status, want.granted_index, want.in_use,
                           rsp_data.status, rsp_data.granted_index, rsp_data.in_use);
               error_count <= error_count + 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // full-size pool out of reset: empty frees, double free, clear
      issue(CMD_FREE, 8'd0);
      issue(CMD_FREE, 8'd255);
      issue(CMD_NOP, 8'd255);
      issue(CMD_ALLOC, 8'd0);
      issue(CMD_ALLOC, 8'd255);
      issue(CMD_ALLOC, 8'd0);
      issue(CMD_FREE, 8'd1);
      issue(CMD_FREE, 8'd1);
      issue(CMD_ALLOC, 8'd0);
      issue(CMD_ALLOC, 8'd0);
      issue(CMD_CLEAR, 8'd255);
      issue(CMD_ALLOC, 8'd0);
      issue(CMD_FREE, 8'd255);
      issue(CMD_ALLOC, 8'd0);
      issue(CMD_CLEAR, 8'd0);

      // zero-sized pool
      set_block_count(9'd0);
      issue(CMD_ALLOC, 8'd0);
      issue(CMD_FREE, 8'd0);
      issue(CMD_FREE, 8'd255);
      issue(CMD_NOP, 8'd0);

      set_block_count(9'd1);
      issue(CMD_ALLOC, 8'd0);
      issue(CMD_ALLOC, 8'd0);
      issue(CMD_FREE, 8'd1);
      issue(CMD_FREE, 8'd0);
      issue(CMD_ALLOC, 8'd0);

      // oversized count saturates; fill the whole pool to exhaustion under a long hold-off
      set_block_count(9'd511);
      issue(CMD_CLEAR, 8'd0);
      random_traffic(300, 95, 0);
      hold_asks = hold_asks + 1;

      set_block_count(9'd2);
      random_traffic(40, 45, 4);
      for (int p = 0; p < 3; p++) begin
         set_block_count(9'($urandom_range(3, 64)));
         random_traffic(45, 50, 4);
      end
      set_block_count(9'd255);
      random_traffic(40, 55, 3);

      // closing stretch at full rate
      set_block_count(9'($urandom_range(3, 20)));
      idle_enable = 1'b0;
      random_traffic(40, 50, 4);

      while (outcome_queue.size() > 0)
         @(posedge clock);
      repeat (DrainPause + 2) @(posedge clock);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
